[rtl/start_length_crc16_deframer_unit_defines.svh]
`ifndef START_LENGTH_CRC16_DEFRAMER_UNIT_DEFINES_SVH
`define START_LENGTH_CRC16_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset.
`define SLCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SLCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/slcd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package slcd_pkg;

  localparam int unsigned CFG_INDEX_W = 8;

  // command codes
  localparam logic [1:0] CMD_ARM  = 2'd0;
  localparam logic [1:0] CMD_BYTE = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_FAIL    = 2'd2;

  // failure reasons
  localparam logic [2:0] FAIL_NONE      = 3'd0;
  localparam logic [2:0] FAIL_HUNT_TO   = 3'd1;
  localparam logic [2:0] FAIL_BYTE_TO   = 3'd2;
  localparam logic [2:0] FAIL_BAD_LEN   = 3'd3;
  localparam logic [2:0] FAIL_CRC       = 3'd4;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 8'd1;

  localparam logic [7:0]  START_BYTE      = 8'hAA;
  localparam logic [7:0]  DEFAULT_TIMEOUT = 8'd200;
  localparam logic [7:0]  DEFAULT_MAX_LEN = 8'd255;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] frame_length;
    logic [2:0] fail_code;
  } result_t;

endpackage

`default_nettype wire

[rtl/slcd_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

interface slcd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface slcd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] frame_length;
  logic [2:0] fail_code;

  modport source (output valid, output kind, output data_byte, output frame_length,
                  output fail_code, input ready);
  modport sink (input valid, input kind, input data_byte, input frame_length,
                input fail_code, output ready);
endinterface

interface slcd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [slcd_pkg::CFG_INDEX_W-1:0] index;
  logic [7:0]                       data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/start_length_crc16_deframer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "start_length_crc16_deframer_unit_defines.svh"

// Length-prefixed frame receiver with CRC-16/MODBUS check. Arm with a cmd 0
// word, then feed received bytes (cmd 1) and millisecond ticks (cmd 2). Each
// payload byte comes out as it arrives; the frame ends with one good or failed
// report, after which the block ignores bytes and ticks until armed again.
// Rate: one input word per clock, sustained. Every word is finished in the
// cycle it is accepted (byte-wide CRC update is a single combinational step)
// and its result, if any, is registered into the output buffer. Results
// sit in a two-entry output buffer; input ready drops only while both
// entries are full. Config writes are taken every cycle (ready tied high).
module start_length_crc16_deframer_unit (
  input  wire          clk,
  input  wire          rst,
  slcd_in_if.sink      item,
  slcd_out_if.source   result,
  slcd_cfg_if.sink     cfg
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HUNT = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRCL = 3'd4;
  localparam logic [2:0] PH_CRCH = 3'd5;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ slcd_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  logic [7:0]  max_payload;
  logic [7:0]  timeout_ticks;

  logic [2:0]  phase, phase_next;
  logic [7:0]  tick_count, tick_count_next;
  logic [7:0]  payload_length, payload_length_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [15:0] crc_accum, crc_accum_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;

  slcd_pkg::result_t res_new;
  logic              push;
  logic              pop;
  logic              acc;

  slcd_pkg::result_t buf0, buf1;
  logic [1:0]        fill;

  logic [7:0]  tick_inc;
  logic [7:0]  left_dec;
  logic [15:0] crc_folded;

  assign acc        = item.valid && item.ready;
  assign pop        = result.valid && result.ready;
  assign item.ready = (fill != 2'd2);
  assign cfg.ready  = 1'b1;

  assign tick_inc   = (tick_count == 8'hFF) ? tick_count : tick_count + 8'd1;
  assign left_dec   = bytes_left - 8'd1;
  assign crc_folded = crc_fold(crc_accum, item.rx_byte);

  always_comb begin
    phase_next          = phase;
    tick_count_next     = tick_count;
    payload_length_next = payload_length;
    bytes_left_next     = bytes_left;
    crc_accum_next      = crc_accum;
    crc_low_byte_next   = crc_low_byte;
    push                = 1'b0;
    res_new             = '0;
    if (acc) begin
      case (item.cmd)
        slcd_pkg::CMD_ARM: begin
          // drops any frame in progress without a report
          phase_next          = PH_HUNT;
          tick_count_next     = 8'd0;
          payload_length_next = 8'd0;
          bytes_left_next     = 8'd0;
          crc_accum_next      = slcd_pkg::CRC_INIT;
          crc_low_byte_next   = 8'd0;
        end
        slcd_pkg::CMD_TICK: begin
          if (phase != PH_IDLE) begin
            tick_count_next = tick_inc;
            if (tick_inc >= timeout_ticks) begin
              phase_next        = PH_IDLE;
              push              = 1'b1;
              res_new.kind      = slcd_pkg::KIND_FAIL;
              res_new.fail_code = (phase == PH_HUNT) ? slcd_pkg::FAIL_HUNT_TO
                                                     : slcd_pkg::FAIL_BYTE_TO;
            end
          end
        end
        slcd_pkg::CMD_BYTE: begin
          case (phase)
            PH_IDLE: begin
            end
            PH_HUNT: begin
              if (item.rx_byte == slcd_pkg::START_BYTE) begin
                phase_next      = PH_LEN;
                tick_count_next = 8'd0;
              end
            end
            PH_LEN: begin
              tick_count_next = 8'd0;
              if (item.rx_byte == 8'd0 || item.rx_byte > max_payload) begin
                phase_next        = PH_IDLE;
                push              = 1'b1;
                res_new.kind      = slcd_pkg::KIND_FAIL;
                res_new.fail_code = slcd_pkg::FAIL_BAD_LEN;
              end else begin
                payload_length_next = item.rx_byte;
                bytes_left_next     = item.rx_byte;
                crc_accum_next      = slcd_pkg::CRC_INIT;
                phase_next          = PH_DATA;
              end
            end
            PH_DATA: begin
              tick_count_next   = 8'd0;
              crc_accum_next    = crc_folded;
              bytes_left_next   = left_dec;
              if (left_dec == 8'd0) begin
                phase_next = PH_CRCL;
              end
              push              = 1'b1;
              res_new.kind      = slcd_pkg::KIND_PAYLOAD;
              res_new.data_byte = item.rx_byte;
            end
            PH_CRCL: begin
              tick_count_next   = 8'd0;
              crc_low_byte_next = item.rx_byte;
              phase_next        = PH_CRCH;
            end
            PH_CRCH: begin
              tick_count_next = 8'd0;
              phase_next      = PH_IDLE;
              push            = 1'b1;
              if ({item.rx_byte, crc_low_byte} == crc_accum) begin
                res_new.kind         = slcd_pkg::KIND_GOOD;
                res_new.frame_length = payload_length;
              end else begin
                res_new.kind      = slcd_pkg::KIND_FAIL;
                res_new.fail_code = slcd_pkg::FAIL_CRC;
              end
            end
            default: begin
              phase_next = PH_IDLE;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload    <= slcd_pkg::DEFAULT_MAX_LEN;
      timeout_ticks  <= slcd_pkg::DEFAULT_TIMEOUT;
      phase          <= PH_IDLE;
      tick_count     <= 8'd0;
      payload_length <= 8'd0;
      bytes_left     <= 8'd0;
      crc_accum      <= slcd_pkg::CRC_INIT;
      crc_low_byte   <= 8'd0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == slcd_pkg::REG_MAX_PAYLOAD) begin
          max_payload <= cfg.data;
        end else if (cfg.index == slcd_pkg::REG_TIMEOUT_TICKS) begin
          timeout_ticks <= cfg.data;
        end
      end
      phase          <= phase_next;
      tick_count     <= tick_count_next;
      payload_length <= payload_length_next;
      bytes_left     <= bytes_left_next;
      crc_accum      <= crc_accum_next;
      crc_low_byte   <= crc_low_byte_next;
    end
  end

  // two-entry result buffer, buf0 is the head
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      if (push && pop) begin
        if (fill == 2'd1) begin
          buf0 <= res_new;
        end else begin
          buf0 <= buf1;
          buf1 <= res_new;
        end
      end else if (pop) begin
        buf0 <= buf1;
        fill <= fill - 2'd1;
      end else if (push) begin
        if (fill == 2'd0) begin
          buf0 <= res_new;
        end else begin
          buf1 <= res_new;
        end
        fill <= fill + 2'd1;
      end
    end
  end

  assign result.valid        = (fill != 2'd0);
  assign result.kind         = buf0.kind;
  assign result.data_byte    = buf0.data_byte;
  assign result.frame_length = buf0.frame_length;
  assign result.fail_code    = buf0.fail_code;

  `SLCD_ASSERT_NOW(a_fill_range, 1'b1, fill != 2'd3, "result buffer fill out of range")
  `SLCD_ASSERT_NOW(a_idle_silent, acc && phase == PH_IDLE && item.cmd != slcd_pkg::CMD_ARM,
                   !push, "result produced while idle")
  `SLCD_ASSERT_NEXT(a_report_idles, push && res_new.kind != slcd_pkg::KIND_PAYLOAD,
                    phase == PH_IDLE, "frame report did not return to idle")
  `SLCD_ASSERT_NOW(a_good_len, push && res_new.kind == slcd_pkg::KIND_GOOD,
                   res_new.frame_length != 8'd0, "good frame with zero length")

endmodule

`default_nettype wire

[sim/start_length_crc16_deframer_unit_test.sv]
`timescale 1ns / 1ps

module start_length_crc16_deframer_unit_test;
  import slcd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_WORDS = 90;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef enum logic [2:0] {
    RX_IDLE, RX_HUNT, RX_LEN, RX_DATA, RX_CRC_LO, RX_CRC_HI
  } rx_state_e;

  class frame_scoreboard;
    logic [7:0]  max_len;
    logic [7:0]  tick_limit;
    rx_state_e   state;
    logic [7:0]  tick_count;
    logic [7:0]  frame_len;
    logic [7:0]  left;
    logic [15:0] crc;
    logic [7:0]  crc_lo;
    result_t     pending[$];
    int          errors;

    function new();
      max_len    = DEFAULT_MAX_LEN;
      tick_limit = DEFAULT_TIMEOUT;
      state      = RX_IDLE;
      tick_count = 8'd0;
      frame_len  = 8'd0;
      left       = 8'd0;
      crc        = CRC_INIT;
      crc_lo     = 8'd0;
      errors     = 0;
    endfunction

    function void set_register(logic [7:0] idx, logic [7:0] val);
      if (idx == REG_MAX_PAYLOAD) max_len = val;
      else if (idx == REG_TIMEOUT_TICKS) tick_limit = val;
    endfunction

    function logic [15:0] crc_fold(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
    endfunction

    function void push(logic [1:0] kind, logic [7:0] data, logic [7:0] len,
                       logic [2:0] code);
      result_t r;
      r.kind = kind;
      r.data_byte = data;
      r.frame_length = len;
      r.fail_code = code;
      pending.push_back(r);
    endfunction

    // returns 1 when the word did something (not dropped while idle, not a spare command)
    function bit note_word(logic [1:0] cmd, logic [7:0] b);
      if (cmd == CMD_ARM) begin
        state      = RX_HUNT;
        tick_count = 8'd0;
        frame_len  = 8'd0;
        left       = 8'd0;
        crc        = CRC_INIT;
        crc_lo     = 8'd0;
        return 1'b1;
      end
      if ((cmd != CMD_BYTE && cmd != CMD_TICK) || state == RX_IDLE) return 1'b0;
      if (cmd == CMD_TICK) begin
        if (tick_count != 8'hFF) tick_count = tick_count + 8'd1;
        if (tick_count >= tick_limit) begin
          push(KIND_FAIL, 8'd0, 8'd0, (state == RX_HUNT) ? FAIL_HUNT_TO : FAIL_BYTE_TO);
          state = RX_IDLE;
        end
        return 1'b1;
      end
      case (state)
        RX_HUNT: begin
          if (b == START_BYTE) begin
            state = RX_LEN;
            tick_count = 8'd0;
          end
        end
        RX_LEN: begin
          tick_count = 8'd0;
          if (b == 8'd0 || b > max_len) begin
            push(KIND_FAIL, 8'd0, 8'd0, FAIL_BAD_LEN);
            state = RX_IDLE;
          end else begin
            frame_len = b;
            left = b;
            crc = CRC_INIT;
            state = RX_DATA;
          end
        end
        RX_DATA: begin
          tick_count = 8'd0;
          crc = crc_fold(crc, b);
          left = left - 8'd1;
          if (left == 8'd0) state = RX_CRC_LO;
          push(KIND_PAYLOAD, b, 8'd0, FAIL_NONE);
        end
        RX_CRC_LO: begin
          tick_count = 8'd0;
          crc_lo = b;
          state = RX_CRC_HI;
        end
        RX_CRC_HI: begin
          tick_count = 8'd0;
          state = RX_IDLE;
          if ({b, crc_lo} == crc) push(KIND_GOOD, 8'd0, frame_len, FAIL_NONE);
          else push(KIND_FAIL, 8'd0, 8'd0, FAIL_CRC);
        end
        default: state = RX_IDLE;
      endcase
      return 1'b1;
    endfunction

    task report_mismatch(string msg);
      if (errors < 50) $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [1:0] kind, logic [7:0] data, logic [7:0] len,
                      logic [2:0] code);
      result_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind %0d data %02h len %0d code %0d",
                                  kind, data, len, code));
        return;
      end
      want = pending.pop_front();
      if (kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
      if (data !== want.data_byte)
        report_mismatch($sformatf("data_byte %02h, want %02h", data, want.data_byte));
      if (len !== want.frame_length)
        report_mismatch($sformatf("frame_length %0d, want %0d", len, want.frame_length));
      if (code !== want.fail_code)
        report_mismatch($sformatf("fail_code %0d, want %0d", code, want.fail_code));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic holding = 1'b0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   words_done = 0;
  int   cycles = 0;
  event hold_off_ev;
  frame_scoreboard sb = new();

  slcd_in_if  in_ch();
  slcd_out_if out_ch();
  slcd_cfg_if cfg_ch();

  start_length_crc16_deframer_unit dut (
    .clk(clk),
    .rst(rst),
    .item(in_ch),
    .result(out_ch),
    .cfg(cfg_ch)
  );

  always #2 clk = ~clk;

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !holding && ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold-off so the output buffer fills and input backs up
  always begin
    @(hold_off_ev);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk)
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.kind, out_ch.data_byte, out_ch.frame_length, out_ch.fail_code);

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_word(logic [1:0] c, logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (sb.note_word(c, b)) words_done++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic [7:0] max_val, logic [7:0] limit_val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_MAX_PAYLOAD;
    cfg_ch.data <= max_val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_register(REG_MAX_PAYLOAD, max_val);
    cfg_ch.index <= REG_TIMEOUT_TICKS;
    cfg_ch.data <= limit_val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_register(REG_TIMEOUT_TICKS, limit_val);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic maybe_tick();
    int n;
    n = 0;
    if ($urandom_range(99) < 10) n = $urandom_range(1, 2);
    else if ($urandom_range(99) < 2 && sb.tick_limit <= 8'd16) n = int'(sb.tick_limit);
    repeat (n) send_word(CMD_TICK, 8'($urandom));
  endtask

  task automatic run_frame();
    int len;
    int top;
    int r;
    int i;
    logic [15:0] crc;
    logic [7:0] b;
    send_word(CMD_ARM, 8'($urandom));
    repeat ($urandom_range(0, 2)) begin
      b = 8'($urandom);
      if (b == START_BYTE) b = ~b;
      send_word(($urandom_range(99) < 75) ? CMD_BYTE : CMD_TICK, b);
    end
    send_word(CMD_BYTE, START_BYTE);
    top = (sb.max_len < 8'd12) ? int'(sb.max_len) : 12;
    r = $urandom_range(99);
    if (sb.max_len == 8'd0) len = $urandom_range(0, 255);
    else if (r < 5) len = 0;
    else if (r < 10 && sb.max_len != 8'hFF) len = $urandom_range(int'(sb.max_len) + 1, 255);
    else if (r < 12) len = int'(sb.max_len);
    else len = $urandom_range(1, top);
    maybe_tick();
    send_word(CMD_BYTE, 8'(len));
    if (len == 0 || len > int'(sb.max_len)) return;
    crc = CRC_INIT;
    for (i = 0; i < len; i++) begin
      maybe_tick();
      // broken frame: re-arm in the middle of the payload
      if ($urandom_range(199) == 0) begin
        send_word(CMD_ARM, 8'($urandom));
        return;
      end
      b = 8'($urandom);
      crc = sb.crc_fold(crc, b);
      send_word(CMD_BYTE, b);
    end
    maybe_tick();
    if ($urandom_range(99) < 12) crc = crc ^ (16'd1 << $urandom_range(15));
    send_word(CMD_BYTE, crc[7:0]);
    maybe_tick();
    send_word(CMD_BYTE, crc[15:8]);
    if ($urandom_range(99) < 20) send_word(2'($urandom_range(CMD_BYTE, CMD_SPARE)), 8'($urandom));
  endtask

  initial begin
    logic [15:0] crc;
    int target;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= CMD_ARM;
    in_ch.rx_byte <= 8'd0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_MAX_PAYLOAD;
    cfg_ch.data <= 8'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle block ignores bytes, ticks and the spare command
    send_word(CMD_BYTE, 8'h55);
    send_word(CMD_TICK, 8'h00);
    send_word(CMD_SPARE, 8'hFF);
    // one-byte good frame with a discarded byte in the hunt
    send_word(CMD_ARM, 8'h00);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, START_BYTE);
    send_word(CMD_BYTE, 8'd1);
    send_word(CMD_BYTE, 8'hFF);
    crc = sb.crc_fold(CRC_INIT, 8'hFF);
    send_word(CMD_BYTE, crc[7:0]);
    send_word(CMD_BYTE, crc[15:8]);
    // zero length
    send_word(CMD_ARM, 8'h00);
    send_word(CMD_BYTE, START_BYTE);
    send_word(CMD_BYTE, 8'd0);
    // re-arm mid-frame, then a crc mismatch
    send_word(CMD_ARM, 8'h00);
    send_word(CMD_BYTE, START_BYTE);
    send_word(CMD_BYTE, 8'd2);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_ARM, 8'h00);
    send_word(CMD_BYTE, START_BYTE);
    send_word(CMD_BYTE, 8'd1);
    send_word(CMD_BYTE, 8'h80);
    crc = sb.crc_fold(CRC_INIT, 8'h80);
    send_word(CMD_BYTE, crc[7:0]);
    send_word(CMD_BYTE, ~crc[15:8]);
    settle();
    // hunt timeout, then every length rejected
    configure(8'd0, 8'd1);
    send_word(CMD_ARM, 8'h00);
    send_word(CMD_TICK, 8'h00);
    send_word(CMD_ARM, 8'h00);
    send_word(CMD_BYTE, START_BYTE);
    send_word(CMD_BYTE, 8'd1);
    settle();
    // zero timeout: first tick after a byte fails
    configure(8'hFF, 8'd0);
    send_word(CMD_ARM, 8'h00);
    send_word(CMD_BYTE, START_BYTE);
    send_word(CMD_TICK, 8'h00);

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: configure(8'hFF, 8'd200);
        1: configure(8'd1, 8'd1);
        2: configure(8'd16, 8'd4);
        3: configure(8'd0, 8'd0);
        4: configure(8'hFF, 8'hFF);
        5: configure(8'd8, 8'd2);
        default: configure(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 77; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 77; end
        default: begin idle_pct = 16; stall_pct <= 16; end
      endcase
      if (ph == 4) -> hold_off_ev;
      target = words_done + PHASE_WORDS;
      while (words_done < target) begin
        if ($urandom_range(99) < 85) run_frame();
        else send_word(2'($urandom_range(CMD_ARM, CMD_SPARE)), 8'($urandom));
      end
    end

    settle();
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
